>>> rtl/delta_sleep_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta sleep queue
// Concurrent assertion wrappers that expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DELTA_SLEEP_QUEUE_TOP_ASSERT_SVH
`define DELTA_SLEEP_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Assertion on an explicit clock and reset.
`define DSQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Assertion on the block clock and reset.
`define DSQ_ASSERT(label, prop, msg) \
   `DSQ_ASSERT_CLK(label, clock, reset, prop, msg)

`else

`define DSQ_ASSERT_CLK(label, clk, rst, prop, msg)

`define DSQ_ASSERT(label, prop, msg)

`endif

`endif

>>> rtl/dsq_pkg.sv
// ----------------------------------------------------------------------------
// Delta sleep queue package
// Shared constants, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsq_pkg;

   localparam int MAX_SLEEPERS_DEF = 16;
   localparam int TASK_ID_BITS_DEF = 8;

   localparam int DELTA_BITS    = 64;
   localparam int WAKE_LIMIT    = 16;
   localparam int WAKE_CNT_BITS = 5;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

   localparam logic       ACTION_SLEEP  = 1'b0;
   localparam logic       ACTION_TICK   = 1'b1;
   localparam logic [3:0] KIND_REALTIME = 4'd0;

   localparam logic [2:0] STATUS_QUEUED    = 3'd0;
   localparam logic [2:0] STATUS_WOKEN     = 3'd1;
   localparam logic [2:0] STATUS_NOTHING   = 3'd2;
   localparam logic [2:0] STATUS_BAD_CLOCK = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_QUEUED,
      EMIT_WOKEN,
      EMIT_WOKEN_LAST,
      EMIT_IDLE_TICK,
      EMIT_BAD_CLOCK,
      EMIT_FULL
   } dsq_emit_type;

   typedef struct packed {
      logic         load;
      logic         mul;
      logic         add_nanos;
      logic         rd_pos;
      logic         rd_next;
      logic         rd_shift;
      logic         sub_d;
      logic         pos_inc;
      logic         save_succ;
      logic         j_load;
      logic         wr_shift;
      logic         wr_succ;
      logic         wr_place;
      logic         wr_adjust;
      logic         pop;
      dsq_emit_type emit;
   } dsq_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic clock_bad;
      logic full;
      logic cnt_zero;
      logic cnt_one;
      logic ge;
      logic more_after;
      logic shift_more;
      logic n_below_limit;
      logic pend_valid;
      logic out_free;
   } dsq_sts_type;

endpackage

`default_nettype wire

>>> rtl/dsq_ctrl.sv
// ----------------------------------------------------------------------------
// Delta sleep queue controller
// Sequences insert, shift and tick wake steps over the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsq_ctrl
   import dsq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  dsq_sts_type      sts,
   output dsq_cmd_type      cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DECODE = 10'b00_0000_0010,
      S_ADD    = 10'b00_0000_0100,
      S_WALK   = 10'b00_0000_1000,
      S_SH_RD  = 10'b00_0001_0000,
      S_SH_WR  = 10'b00_0010_0000,
      S_SUCC   = 10'b00_0100_0000,
      S_PLACE  = 10'b00_1000_0000,
      S_T_CMP  = 10'b01_0000_0000,
      S_T_FIN  = 10'b10_0000_0000
   } dsq_state_type;

   dsq_state_type state_ff;
   dsq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_tick) begin
               if (sts.cnt_zero) begin
                  state_in = S_T_FIN;
               end else begin
                  cmd.rd_pos = 1'b1;
                  state_in   = S_T_CMP;
               end
            end else if (sts.clock_bad) begin
               if (sts.out_free) begin
                  cmd.emit = EMIT_BAD_CLOCK;
                  state_in = S_IDLE;
               end
            end else if (sts.full) begin
               if (sts.out_free) begin
                  cmd.emit = EMIT_FULL;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_nanos = 1'b1;
            if (sts.cnt_zero) begin
               state_in = S_PLACE;
            end else begin
               cmd.rd_pos = 1'b1;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.ge) begin
               cmd.sub_d   = 1'b1;
               cmd.pos_inc = 1'b1;
               if (sts.more_after) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               cmd.save_succ = 1'b1;
               cmd.j_load    = 1'b1;
               state_in      = sts.more_after ? S_SH_RD : S_SUCC;
            end
         end
         S_SH_RD: begin
            cmd.rd_shift = 1'b1;
            state_in     = S_SH_WR;
         end
         S_SH_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = sts.shift_more ? S_SH_RD : S_SUCC;
         end
         S_SUCC: begin
            cmd.wr_succ = 1'b1;
            state_in    = S_PLACE;
         end
         S_PLACE: begin
            if (sts.out_free) begin
               cmd.wr_place = 1'b1;
               cmd.emit     = EMIT_QUEUED;
               state_in     = S_IDLE;
            end
         end
         S_T_CMP: begin
            if (sts.ge && sts.n_below_limit) begin
               if (!sts.pend_valid || sts.out_free) begin
                  if (sts.pend_valid) begin
                     cmd.emit = EMIT_WOKEN;
                  end
                  cmd.sub_d = 1'b1;
                  cmd.pop   = 1'b1;
                  if (sts.cnt_one) begin
                     state_in = S_T_FIN;
                  end else begin
                     cmd.rd_next = 1'b1;
                  end
               end
            end else begin
               cmd.wr_adjust = 1'b1;
               state_in      = S_T_FIN;
            end
         end
         S_T_FIN: begin
            if (sts.out_free) begin
               cmd.emit = sts.pend_valid ? EMIT_WOKEN_LAST : EMIT_IDLE_TICK;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/dsq_dpath.sv
// ----------------------------------------------------------------------------
// Delta sleep queue datapath
// Entry memory as a ring, duration arithmetic, walk indexes and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "delta_sleep_queue_top_assert.svh"

module dsq_dpath
   import dsq_pkg::*;
#(
   parameter int MAX_SLEEPERS = MAX_SLEEPERS_DEF,
   parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  dsq_cmd_type      cmd,
   output dsq_sts_type      sts,
   input  wire logic        req_action,
   input  wire logic [3:0]  req_clock_kind,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [31:0] req_sleep_seconds,
   input  wire logic [29:0] req_sleep_nanos,
   input  wire logic [63:0] req_tick_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_woken_task,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);

   localparam int AW = $clog2(MAX_SLEEPERS);
   localparam int CW = $clog2(MAX_SLEEPERS + 1);
   localparam int TB = TASK_ID_BITS;
   localparam int EW = TB + DELTA_BITS;
   localparam logic [AW:0]   MAX_W  = (AW + 1)'(MAX_SLEEPERS);
   localparam logic [AW-1:0] LAST_A = AW'(MAX_SLEEPERS - 1);

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [AW:0] idx);
      logic [AW:0] s;
      s = {1'b0, base} + idx;
      if (s >= MAX_W) begin
         s = s - MAX_W;
      end
      return s[AW-1:0];
   endfunction

   // Entry memory: {task, delta}, ring addressed from head_ff.
   logic [EW-1:0] mem [MAX_SLEEPERS];
   logic [EW-1:0] rd_ff;

   logic                    act_ff;
   logic [3:0]              clk_ff;
   logic [TB-1:0]           task_ff;
   logic [31:0]             secs_ff;
   logic [29:0]             nanos_ff;
   logic [DELTA_BITS-1:0]   d_ff, d_in;
   logic [DELTA_BITS-1:0]   succ_delta_ff;
   logic [TB-1:0]           succ_task_ff;
   logic [TB-1:0]           pend_task_ff;
   logic                    pend_valid_ff, pend_valid_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           j_ff, j_in;
   logic [WAKE_CNT_BITS-1:0] n_ff, n_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_task_ff, rsp_task_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [15:0]             task_wide;
   logic [15:0]             emit_wide;
   logic [TB-1:0]           emit_task;
   logic [61:0]             prod;
   logic [DELTA_BITS-1:0]   rd_delta;
   logic [TB-1:0]           rd_task;
   logic [DELTA_BITS-1:0]   diff;
   logic [DELTA_BITS-1:0]   adj;
   logic                    ge;
   logic                    out_free;
   logic [AW:0]             pos_x, pos1_x, j_x, jm1_x;
   logic                    re;
   logic [AW-1:0]           raddr;
   logic                    we;
   logic [AW-1:0]           waddr;
   logic [EW-1:0]           wdata;
   logic [3:0]              wr_sel;

   assign task_wide = {8'b0, req_task_id};
   assign prod      = secs_ff * NS_PER_SEC;
   assign rd_delta  = rd_ff[DELTA_BITS-1:0];
   assign rd_task   = rd_ff[EW-1:DELTA_BITS];
   assign ge        = (d_ff >= rd_delta);
   assign diff      = rd_delta - d_ff;
   assign adj       = ge ? '0 : diff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pos_x  = (AW + 1)'(pos_ff);
   assign pos1_x = pos_x + (AW + 1)'(1);
   assign j_x    = (AW + 1)'(j_ff);
   assign jm1_x  = j_x - (AW + 1)'(1);

   // Status toward the controller.
   always_comb begin
      sts.is_tick       = (act_ff == ACTION_TICK);
      sts.clock_bad     = (clk_ff != KIND_REALTIME);
      sts.full          = (cnt_ff == CW'(MAX_SLEEPERS));
      sts.cnt_zero      = (cnt_ff == '0);
      sts.cnt_one       = (cnt_ff == CW'(1));
      sts.ge            = ge;
      sts.more_after    = (({1'b0, pos_ff} + (CW + 1)'(1)) < {1'b0, cnt_ff});
      sts.shift_more    = ({1'b0, j_ff} > ({1'b0, pos_ff} + (CW + 1)'(2)));
      sts.n_below_limit = (n_ff < WAKE_CNT_BITS'(WAKE_LIMIT));
      sts.pend_valid    = pend_valid_ff;
      sts.out_free      = out_free;
   end

   // Memory port selection.
   assign re     = cmd.rd_pos || cmd.rd_next || cmd.rd_shift;
   assign wr_sel = {cmd.wr_shift, cmd.wr_succ, cmd.wr_place, cmd.wr_adjust};
   assign we     = (wr_sel != '0);

   always_comb begin
      raddr = phys(head_ff, pos_x);
      if (cmd.rd_next) begin
         raddr = phys(head_ff, pos1_x);
      end else if (cmd.rd_shift) begin
         raddr = phys(head_ff, jm1_x);
      end
   end

   always_comb begin
      waddr = phys(head_ff, pos_x);
      wdata = {task_ff, d_ff};
      if (cmd.wr_shift) begin
         waddr = phys(head_ff, j_x);
         wdata = rd_ff;
      end else if (cmd.wr_succ) begin
         waddr = phys(head_ff, pos1_x);
         wdata = {succ_task_ff, succ_delta_ff};
      end else if (cmd.wr_adjust) begin
         waddr = head_ff;
         wdata = {rd_task, adj};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   // Working registers.
   always_comb begin
      d_in = d_ff;
      if (cmd.load) begin
         d_in = (req_action == ACTION_TICK) ? req_tick_ns : '0;
      end else if (cmd.mul) begin
         d_in = DELTA_BITS'(prod);
      end else if (cmd.add_nanos) begin
         d_in = d_ff + DELTA_BITS'(nanos_ff);
      end else if (cmd.sub_d) begin
         d_in = d_ff - rd_delta;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         clk_ff   <= req_clock_kind;
         task_ff  <= task_wide[TB-1:0];
         secs_ff  <= req_sleep_seconds;
         nanos_ff <= req_sleep_nanos;
      end
      d_ff <= d_in;
      if (cmd.save_succ) begin
         succ_delta_ff <= diff;
         succ_task_ff  <= rd_task;
      end
      if (cmd.pop) begin
         pend_task_ff <= rd_task;
      end
      pos_ff <= pos_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = '0;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + CW'(1);
      end
      j_in = j_ff;
      if (cmd.j_load) begin
         j_in = cnt_ff;
      end else if (cmd.wr_shift) begin
         j_in = j_ff - CW'(1);
      end
      n_in = n_ff;
      if (cmd.load) begin
         n_in = '0;
      end else if (cmd.pop) begin
         n_in = n_ff + WAKE_CNT_BITS'(1);
      end
   end

   // Queue occupancy and ring head.
   always_comb begin
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.wr_place) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.pop) begin
         cnt_in        = cnt_ff - CW'(1);
         head_in       = (head_ff == LAST_A) ? '0 : head_ff + AW'(1);
         pend_valid_in = 1'b1;
      end
      if (cmd.load) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         head_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Result register.
   assign emit_task = (cmd.emit == EMIT_QUEUED) ? task_ff : pend_task_ff;
   assign emit_wide = 16'(emit_task);

   always_comb begin
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (cmd.emit)
         EMIT_NONE: begin
         end
         EMIT_QUEUED: begin
            rsp_task_in   = emit_wide[7:0];
            rsp_status_in = STATUS_QUEUED;
            rsp_last_in   = 1'b1;
         end
         EMIT_WOKEN: begin
            rsp_task_in   = emit_wide[7:0];
            rsp_status_in = STATUS_WOKEN;
            rsp_last_in   = 1'b0;
         end
         EMIT_WOKEN_LAST: begin
            rsp_task_in   = emit_wide[7:0];
            rsp_status_in = STATUS_WOKEN;
            rsp_last_in   = 1'b1;
         end
         EMIT_IDLE_TICK: begin
            rsp_task_in   = '0;
            rsp_status_in = STATUS_NOTHING;
            rsp_last_in   = 1'b1;
         end
         EMIT_BAD_CLOCK: begin
            rsp_task_in   = '0;
            rsp_status_in = STATUS_BAD_CLOCK;
            rsp_last_in   = 1'b1;
         end
         EMIT_FULL: begin
            rsp_task_in   = '0;
            rsp_status_in = STATUS_FULL;
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_woken_task = rsp_task_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   `DSQ_ASSERT(a_single_write, $onehot0(wr_sel), "two memory writes in one cycle")
   `DSQ_ASSERT(a_emit_slot_free, (cmd.emit != EMIT_NONE) |-> out_free, "result overwritten")
   `DSQ_ASSERT(a_count_bound, cnt_ff <= CW'(MAX_SLEEPERS), "entry count above table depth")
   `DSQ_ASSERT(a_pop_nonempty, cmd.pop |-> (cnt_ff != '0), "wake from an empty queue")
   `DSQ_ASSERT(a_place_room, cmd.wr_place |-> !sts.full, "insert into a full queue")

endmodule

`default_nettype wire

>>> rtl/delta_sleep_queue_top.sv
// ----------------------------------------------------------------------------
// Delta sleep queue top level
// One request beat is in work at a time; an insert shifts the entries behind its point
// with a read and then a write for each entry. Reset clears the state, entry count, ring
// head and result slot, not the memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delta_sleep_queue_top
   import dsq_pkg::*;
#(
   parameter int MAX_SLEEPERS = MAX_SLEEPERS_DEF,
   parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [3:0]  req_clock_kind,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [31:0] req_sleep_seconds,
   input  wire logic [29:0] req_sleep_nanos,
   input  wire logic [63:0] req_tick_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_woken_task,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);

   // The controller owns sequencing; the datapath owns every stored value.
   // They talk only through the command and status structs below.
   dsq_cmd_type cmd;
   dsq_sts_type sts;

   // The controller takes a new request beat only when idle. Results leave
   // through a registered slot in the datapath, so a request beat can be
   // taken while the previous result still waits on rsp_stall.
   dsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath keeps the sorted delta list as a ring in one memory.
   // Waking a task advances the ring head, so a tick never moves entries;
   // an insert shifts the entries behind the insert point one slot down.
   dsq_dpath #(
      .MAX_SLEEPERS (MAX_SLEEPERS),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_clock_kind    (req_clock_kind),
      .req_task_id       (req_task_id),
      .req_sleep_seconds (req_sleep_seconds),
      .req_sleep_nanos   (req_sleep_nanos),
      .req_tick_ns       (req_tick_ns),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_woken_task    (rsp_woken_task),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire
